// File: design/fsg_pkg.sv
// shared constants for the frustum segment geometry core
`default_nettype none

package fsg_pkg;

   localparam int FRAC_BITS   = 8;
   localparam int COORD_WIDTH = 24;
   localparam int DIAM_WIDTH  = 24;
   localparam int LEN_WIDTH   = 25;
   localparam int VOL_WIDTH   = 60;
   localparam int AREA_WIDTH  = 44;

   localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
   localparam logic [63:0] PI12_Q60 = PI_Q60 / 64'd12;

   localparam int VOL_SHIFT  = 60 + 2 * FRAC_BITS;
   localparam int AREA_SHIFT = 60 + FRAC_BITS + 2;

   localparam int RAD_WIDTH  = 52;
   localparam int ROOT_WIDTH = 26;
   localparam int REM_WIDTH  = 28;
   localparam int SQRT_STEPS = 26;
   localparam int SQRT_LAT   = SQRT_STEPS + 2;
   localparam int PIPE_LAT   = SQRT_LAT + 8;

endpackage

`default_nettype wire

// File: design/fsg_sqrt.sv
// pipelined rounded square root, one result bit per stage
`default_nettype none

module fsg_sqrt
   import fsg_pkg::*;
(
   input  logic                  clock,
   input  logic [RAD_WIDTH-1:0]  rad_value,
   output logic [ROOT_WIDTH:0]   root_out
);

   logic [RAD_WIDTH-1:0]  rad_ff  [0:SQRT_STEPS];
   logic [REM_WIDTH-1:0]  rem_ff  [0:SQRT_STEPS];
   logic [ROOT_WIDTH-1:0] root_ff [0:SQRT_STEPS];
   logic [RAD_WIDTH-1:0]  rad_in  [1:SQRT_STEPS];
   logic [REM_WIDTH-1:0]  rem_in  [1:SQRT_STEPS];
   logic [ROOT_WIDTH-1:0] root_in [1:SQRT_STEPS];
   logic [ROOT_WIDTH:0]   root_out_ff;
   logic [ROOT_WIDTH:0]   root_out_in;

   always_ff @(posedge clock) begin
      rad_ff[0]  <= rad_value;
      rem_ff[0]  <= '0;
      root_ff[0] <= '0;
   end

   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
      logic [REM_WIDTH+1:0] cur;
      logic [REM_WIDTH+1:0] trial;

      always_comb begin
         cur   = {rem_ff[i], rad_ff[i][RAD_WIDTH-1 -: 2]};
         trial = {{(REM_WIDTH-ROOT_WIDTH){1'b0}}, root_ff[i], 2'b01};
         rad_in[i+1] = {rad_ff[i][RAD_WIDTH-3:0], 2'b00};
         if (cur >= trial) begin
            rem_in[i+1]  = REM_WIDTH'(cur - trial);
            root_in[i+1] = {root_ff[i][ROOT_WIDTH-2:0], 1'b1};
         end else begin
            rem_in[i+1]  = REM_WIDTH'(cur);
            root_in[i+1] = {root_ff[i][ROOT_WIDTH-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         rad_ff[i+1]  <= rad_in[i+1];
         rem_ff[i+1]  <= rem_in[i+1];
         root_ff[i+1] <= root_in[i+1];
      end
   end

   // round to nearest: bump when remainder exceeds root
   assign root_out_in = (ROOT_WIDTH+1)'(root_ff[SQRT_STEPS])
      + (ROOT_WIDTH+1)'(rem_ff[SQRT_STEPS]
                        > {{(REM_WIDTH-ROOT_WIDTH){1'b0}}, root_ff[SQRT_STEPS]});

   always_ff @(posedge clock) begin
      root_out_ff <= root_out_in;
   end

   assign root_out = root_out_ff;

endmodule

`default_nettype wire

// File: design/frustum_segment_geometry_core.sv
// top level: segment length, frustum volume and lateral area pipeline
// throughput: one beat per cycle, busy is always low, the receiver cannot stall
// depth is set by the two bit-per-stage square root pipelines
// plus two input stages, five multiply/sum stages and the output register
// reset: synchronous, clears all valid bits; data registers are not reset
`default_nettype none

module frustum_segment_geometry_core
   import fsg_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_prox_present,
   input  logic signed [COORD_WIDTH-1:0] req_prox_x,
   input  logic signed [COORD_WIDTH-1:0] req_prox_y,
   input  logic signed [COORD_WIDTH-1:0] req_prox_z,
   input  logic [DIAM_WIDTH-1:0]         req_prox_diam,
   input  logic signed [COORD_WIDTH-1:0] req_dist_x,
   input  logic signed [COORD_WIDTH-1:0] req_dist_y,
   input  logic signed [COORD_WIDTH-1:0] req_dist_z,
   input  logic [DIAM_WIDTH-1:0]         req_dist_diam,
   output logic                          rsp_strobe,
   output logic [LEN_WIDTH-1:0]          rsp_seg_length,
   output logic [VOL_WIDTH-1:0]          rsp_seg_volume,
   output logic [AREA_WIDTH-1:0]         rsp_seg_area,
   output logic                          rsp_missing_prox
);

   localparam int SQ_W   = 2 * COORD_WIDTH;
   localparam int Q_W    = 50;
   localparam int A_W    = 75;
   localparam int B_W    = 52;
   localparam int VP_W   = 55;
   localparam int AP_W   = 57;
   localparam int VSUM_W = 135;
   localparam int ASUM_W = 115;

   localparam logic [29:0] K12_LO = PI12_Q60[29:0];
   localparam logic [29:0] K12_HI = PI12_Q60[59:30];
   localparam logic [30:0] KPI_LO = PI_Q60[30:0];
   localparam logic [30:0] KPI_HI = PI_Q60[61:31];

   function automatic logic [COORD_WIDTH-1:0] abs_diff(
      input logic signed [COORD_WIDTH-1:0] a,
      input logic signed [COORD_WIDTH-1:0] b);
      logic signed [COORD_WIDTH:0] d;
      d = (COORD_WIDTH+1)'(a) - (COORD_WIDTH+1)'(b);
      abs_diff = d[COORD_WIDTH] ? COORD_WIDTH'(-d) : COORD_WIDTH'(d);
   endfunction

   logic accept;

   // stage 1: differences, diameters and diameter sum
   logic                   v1_ff, pres1_ff;
   logic [COORD_WIDTH-1:0] dx1_ff, dy1_ff, dz1_ff;
   logic [DIAM_WIDTH-1:0]  d1_1_ff, d2_1_ff, dd1_ff;
   logic [DIAM_WIDTH:0]    dsum1_ff;

   // stage 2: squares and products
   logic                v2_ff, pres2_ff;
   logic [SQ_W-1:0]     sqx2_ff, sqy2_ff, sqz2_ff, sqdd2_ff, sq1_2_ff, sq2_2_ff, p12_2_ff;
   logic [DIAM_WIDTH:0] dsum2_ff;

   logic [Q_W-1:0]       s2_sum;
   logic [RAD_WIDTH-1:0] rad_len, rad_t;
   logic [Q_W-1:0]       q_in;

   // delay line alongside the square roots
   logic                v_dly_ff    [0:SQRT_LAT-1];
   logic                pres_dly_ff [0:SQRT_LAT-1];
   logic [Q_W-1:0]      q_dly_ff    [0:SQRT_LAT-1];
   logic [DIAM_WIDTH:0] dsum_dly_ff [0:SQRT_LAT-1];

   logic [ROOT_WIDTH:0] root_len, root_t;

   // multiply stages
   logic                 vm1_ff, pm1_ff, vm2_ff, pm2_ff, vm3_ff, pm3_ff;
   logic                 vm4_ff, pm4_ff, vm5_ff, pm5_ff;
   logic [LEN_WIDTH-1:0] len1_ff, len2_ff, len3_ff, len4_ff, len5_ff;
   logic [Q_W-1:0]       pa_lo1_ff, pa_hi1_ff;
   logic [B_W-1:0]       b1_ff, b2_ff;
   logic [A_W-1:0]       a2_ff;
   logic [VP_W-1:0]      vp00_ff, vp01_ff, vp10_ff, vp11_ff, vp20_ff, vp21_ff;
   logic [AP_W-1:0]      ap00_ff, ap01_ff, ap10_ff, ap11_ff;
   logic [VSUM_W-1:0]    vsa_ff, vsb_ff, vsum_ff;
   logic [ASUM_W-1:0]    asa_ff, asb_ff, asum_ff;

   logic [VSUM_W-1:0] vol_sh;
   logic [ASUM_W-1:0] area_sh;

   logic                  rsp_strobe_ff, rsp_missing_ff;
   logic [LEN_WIDTH-1:0]  rsp_len_ff;
   logic [VOL_WIDTH-1:0]  rsp_vol_ff;
   logic [AREA_WIDTH-1:0] rsp_area_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         vm1_ff        <= 1'b0;
         vm2_ff        <= 1'b0;
         vm3_ff        <= 1'b0;
         vm4_ff        <= 1'b0;
         vm5_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < SQRT_LAT; i++) begin
            v_dly_ff[i] <= 1'b0;
         end
      end else begin
         v1_ff       <= accept;
         v2_ff       <= v1_ff;
         v_dly_ff[0] <= v2_ff;
         for (int i = 1; i < SQRT_LAT; i++) begin
            v_dly_ff[i] <= v_dly_ff[i-1];
         end
         vm1_ff        <= v_dly_ff[SQRT_LAT-1];
         vm2_ff        <= vm1_ff;
         vm3_ff        <= vm2_ff;
         vm4_ff        <= vm3_ff;
         vm5_ff        <= vm4_ff;
         rsp_strobe_ff <= vm5_ff;
      end
   end

   // stages 1 and 2
   always_ff @(posedge clock) begin
      pres1_ff <= req_prox_present;
      dx1_ff   <= abs_diff(req_prox_x, req_dist_x);
      dy1_ff   <= abs_diff(req_prox_y, req_dist_y);
      dz1_ff   <= abs_diff(req_prox_z, req_dist_z);
      d1_1_ff  <= req_prox_diam;
      d2_1_ff  <= req_dist_diam;
      dd1_ff   <= (req_prox_diam > req_dist_diam) ? req_prox_diam - req_dist_diam
                                                  : req_dist_diam - req_prox_diam;
      dsum1_ff <= (DIAM_WIDTH+1)'(req_prox_diam) + (DIAM_WIDTH+1)'(req_dist_diam);

      pres2_ff <= pres1_ff;
      sqx2_ff  <= SQ_W'(dx1_ff) * SQ_W'(dx1_ff);
      sqy2_ff  <= SQ_W'(dy1_ff) * SQ_W'(dy1_ff);
      sqz2_ff  <= SQ_W'(dz1_ff) * SQ_W'(dz1_ff);
      sqdd2_ff <= SQ_W'(dd1_ff) * SQ_W'(dd1_ff);
      sq1_2_ff <= SQ_W'(d1_1_ff) * SQ_W'(d1_1_ff);
      sq2_2_ff <= SQ_W'(d2_1_ff) * SQ_W'(d2_1_ff);
      p12_2_ff <= SQ_W'(d1_1_ff) * SQ_W'(d2_1_ff);
      dsum2_ff <= dsum1_ff;
   end

   assign s2_sum  = Q_W'(sqx2_ff) + Q_W'(sqy2_ff) + Q_W'(sqz2_ff);
   assign rad_len = RAD_WIDTH'(s2_sum);
   assign rad_t   = {s2_sum, 2'b00} + RAD_WIDTH'(sqdd2_ff);
   assign q_in    = Q_W'(sq1_2_ff) + Q_W'(sq2_2_ff) + Q_W'(p12_2_ff);

   fsg_sqrt u_sqrt_len (
      .clock     (clock),
      .rad_value (rad_len),
      .root_out  (root_len)
   );

   fsg_sqrt u_sqrt_slant (
      .clock     (clock),
      .rad_value (rad_t),
      .root_out  (root_t)
   );

   always_ff @(posedge clock) begin
      pres_dly_ff[0] <= pres2_ff;
      q_dly_ff[0]    <= q_in;
      dsum_dly_ff[0] <= dsum2_ff;
      for (int i = 1; i < SQRT_LAT; i++) begin
         pres_dly_ff[i] <= pres_dly_ff[i-1];
         q_dly_ff[i]    <= q_dly_ff[i-1];
         dsum_dly_ff[i] <= dsum_dly_ff[i-1];
      end
   end

   // multiply, sum, round
   always_ff @(posedge clock) begin
      pm1_ff    <= pres_dly_ff[SQRT_LAT-1];
      len1_ff   <= root_len[LEN_WIDTH-1:0];
      pa_lo1_ff <= Q_W'(root_len[LEN_WIDTH-1:0]) * Q_W'(q_dly_ff[SQRT_LAT-1][24:0]);
      pa_hi1_ff <= Q_W'(root_len[LEN_WIDTH-1:0]) * Q_W'(q_dly_ff[SQRT_LAT-1][49:25]);
      b1_ff     <= B_W'(dsum_dly_ff[SQRT_LAT-1]) * B_W'(root_t);

      pm2_ff  <= pm1_ff;
      len2_ff <= len1_ff;
      a2_ff   <= (A_W'(pa_hi1_ff) << 25) + A_W'(pa_lo1_ff);
      b2_ff   <= b1_ff;

      pm3_ff  <= pm2_ff;
      len3_ff <= len2_ff;
      vp00_ff <= VP_W'(a2_ff[24:0])  * VP_W'(K12_LO);
      vp01_ff <= VP_W'(a2_ff[24:0])  * VP_W'(K12_HI);
      vp10_ff <= VP_W'(a2_ff[49:25]) * VP_W'(K12_LO);
      vp11_ff <= VP_W'(a2_ff[49:25]) * VP_W'(K12_HI);
      vp20_ff <= VP_W'(a2_ff[74:50]) * VP_W'(K12_LO);
      vp21_ff <= VP_W'(a2_ff[74:50]) * VP_W'(K12_HI);
      ap00_ff <= AP_W'(b2_ff[25:0])  * AP_W'(KPI_LO);
      ap01_ff <= AP_W'(b2_ff[25:0])  * AP_W'(KPI_HI);
      ap10_ff <= AP_W'(b2_ff[51:26]) * AP_W'(KPI_LO);
      ap11_ff <= AP_W'(b2_ff[51:26]) * AP_W'(KPI_HI);

      pm4_ff  <= pm3_ff;
      len4_ff <= len3_ff;
      vsa_ff  <= VSUM_W'(vp00_ff) + (VSUM_W'(vp10_ff) << 25) + (VSUM_W'(vp20_ff) << 50);
      vsb_ff  <= (VSUM_W'(vp01_ff) << 30) + (VSUM_W'(vp11_ff) << 55)
                 + (VSUM_W'(vp21_ff) << 80);
      asa_ff  <= ASUM_W'(ap00_ff) + (ASUM_W'(ap10_ff) << 26);
      asb_ff  <= (ASUM_W'(ap01_ff) << 31) + (ASUM_W'(ap11_ff) << 57);

      pm5_ff  <= pm4_ff;
      len5_ff <= len4_ff;
      vsum_ff <= vsa_ff + vsb_ff + (VSUM_W'(1) << (VOL_SHIFT - 1));
      asum_ff <= asa_ff + asb_ff + (ASUM_W'(1) << (AREA_SHIFT - 1));
   end

   assign vol_sh  = vsum_ff >> VOL_SHIFT;
   assign area_sh = asum_ff >> AREA_SHIFT;

   always_ff @(posedge clock) begin
      if (!pm5_ff) begin
         rsp_missing_ff <= 1'b1;
         rsp_len_ff     <= '0;
         rsp_vol_ff     <= '0;
         rsp_area_ff    <= '0;
      end else begin
         rsp_missing_ff <= 1'b0;
         rsp_len_ff     <= len5_ff;
         rsp_vol_ff     <= (vol_sh[VSUM_W-1:VOL_WIDTH] != '0) ? '1
                                                              : vol_sh[VOL_WIDTH-1:0];
         rsp_area_ff    <= (area_sh[ASUM_W-1:AREA_WIDTH] != '0) ? '1
                                                                : area_sh[AREA_WIDTH-1:0];
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_seg_length   = rsp_len_ff;
   assign rsp_seg_volume   = rsp_vol_ff;
   assign rsp_seg_area     = rsp_area_ff;
   assign rsp_missing_prox = rsp_missing_ff;

   a_fixed_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##PIPE_LAT rsp_strobe)
      else $error("result strobe missing after pipeline latency");

   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, PIPE_LAT))
      else $error("result strobe without a matching accepted beat");

   a_missing_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_missing_prox) |->
         (rsp_seg_length == '0 && rsp_seg_volume == '0 && rsp_seg_area == '0))
      else $error("absent proximal point must give zero results");

endmodule

`default_nettype wire
